[sv/lpg_pkg.sv]
// shared constants, types and the cordic arctangent table for the georeferencing block
package lpg_pkg;

    localparam int TRIG_FRAC_BITS = 16;
    localparam int POS_BITS       = 35;
    localparam int ANGLE_W        = 16;
    localparam int RANGE_W        = 18;
    localparam int TIME_W         = 48;
    localparam int CFG_W          = 16;
    localparam int CFG_IDX_W      = 3;

    localparam int CORDIC_W       = 34;
    localparam int CORDIC_ITERS   = 30;
    localparam int CORDIC_LAT     = CORDIC_ITERS + 2;
    localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = CORDIC_W'(64'd652032874);

    localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
    localparam int ENT_W          = TRIG_FRAC_BITS + 4;
    localparam int PROD_W         = 2 * ENT_W;
    localparam int MSUM_W         = PROD_W + 2;

    localparam int MM_LAT         = 2;
    localparam int ROT_LAT        = 2 * MM_LAT;
    localparam int SCAN_LAT       = 2;
    localparam int SV_W           = RANGE_W + 2;
    localparam int MAT_DONE       = CORDIC_LAT + ROT_LAT + MM_LAT;
    localparam int SCAN_DLY       = MAT_DONE - CORDIC_LAT - SCAN_LAT;
    localparam int RP_DLY         = MM_LAT;
    localparam int FIN_LAT        = 2;
    localparam int PIPE_LAT       = MAT_DONE + FIN_LAT;

    localparam int ACC_W          = ENT_W + SV_W + 3;
    localparam int OFF_W          = ACC_W - TRIG_FRAC_BITS;
    localparam int GND_W          = ((POS_BITS > OFF_W) ? POS_BITS : OFF_W) + 1;

    localparam logic [CFG_IDX_W-1:0] REG_LEVER_X  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEVER_Y  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVER_Z  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BS_OMEGA = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BS_PHI   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BS_KAPPA = 3'd5;

    typedef logic signed [TRIG_W-1:0] trig_t;
    typedef logic signed [ENT_W-1:0]  ent_t;
    typedef ent_t [2:0][2:0]          mat_t;

    function automatic logic signed [CORDIC_W-1:0] cordic_atan(input int idx);
        logic [31:0] v;
        begin
            case (idx)
                0:  v = 32'h20000000;
                1:  v = 32'h12E4051E;
                2:  v = 32'h09FB385B;
                3:  v = 32'h051111D4;
                4:  v = 32'h028B0D43;
                5:  v = 32'h0145D7E1;
                6:  v = 32'h00A2F61E;
                7:  v = 32'h00517C55;
                8:  v = 32'h0028BE53;
                9:  v = 32'h00145F2F;
                10: v = 32'h000A2F98;
                11: v = 32'h000517CC;
                12: v = 32'h00028BE6;
                13: v = 32'h000145F3;
                14: v = 32'h0000A2FA;
                15: v = 32'h0000517D;
                16: v = 32'h000028BE;
                17: v = 32'h0000145F;
                18: v = 32'h00000A30;
                19: v = 32'h00000518;
                20: v = 32'h0000028C;
                21: v = 32'h00000146;
                22: v = 32'h000000A3;
                23: v = 32'h00000051;
                24: v = 32'h00000029;
                25: v = 32'h00000014;
                26: v = 32'h0000000A;
                27: v = 32'h00000005;
                28: v = 32'h00000003;
                29: v = 32'h00000001;
                default: v = 32'h0;
            endcase
            return CORDIC_W'(v);
        end
    endfunction

endpackage

[sv/lpg_cordic.sv]
// pipelined rotation-mode cordic giving sine and cosine of a binary angle
module lpg_cordic
    import lpg_pkg::*;
(
    input  logic                      clk,
    input  logic                      en,
    input  logic signed [ANGLE_W-1:0] angle,
    output trig_t                     sin_q,
    output trig_t                     cos_q
);

    localparam int RND_SH = 30 - TRIG_FRAC_BITS;
    localparam logic signed [CORDIC_W-1:0] HALF_TURN = CORDIC_W'(64'h4000_0000);
    localparam logic signed [CORDIC_W-1:0] FULL_TURN = CORDIC_W'(64'h8000_0000);
    localparam logic signed [CORDIC_W-1:0] RND_HALF  = CORDIC_W'(64'd1 << (RND_SH - 1));
    localparam logic signed [CORDIC_W-1:0] ONE_Q     = CORDIC_W'(64'd1 << TRIG_FRAC_BITS);

    logic signed [CORDIC_W-1:0] x_reg [0:CORDIC_ITERS];
    logic signed [CORDIC_W-1:0] y_reg [0:CORDIC_ITERS];
    logic signed [CORDIC_W-1:0] z_reg [0:CORDIC_ITERS];
    logic                       neg_reg [0:CORDIC_ITERS];

    logic signed [CORDIC_W-1:0] z_in;
    logic signed [CORDIC_W-1:0] z_fold;
    logic                       neg_in;
    logic signed [CORDIC_W-1:0] x_f;
    logic signed [CORDIC_W-1:0] y_f;
    logic signed [CORDIC_W-1:0] x_r;
    logic signed [CORDIC_W-1:0] y_r;
    trig_t                      sin_reg;
    trig_t                      cos_reg;

    // fold into the right half plane
    always_comb
    begin
        z_in = {{(CORDIC_W-ANGLE_W-16){angle[ANGLE_W-1]}}, angle, 16'b0};
        if (z_in > HALF_TURN)
        begin
            z_fold = z_in - FULL_TURN;
            neg_in = 1'b1;
        end
        else if (z_in < -HALF_TURN)
        begin
            z_fold = z_in + FULL_TURN;
            neg_in = 1'b1;
        end
        else
        begin
            z_fold = z_in;
            neg_in = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]   <= CORDIC_X0;
            y_reg[0]   <= '0;
            z_reg[0]   <= z_fold;
            neg_reg[0] <= neg_in;
        end
    end

    for (genvar i = 0; i < CORDIC_ITERS; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - cordic_atan(i);
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + cordic_atan(i);
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_comb
    begin
        x_f = neg_reg[CORDIC_ITERS] ? -x_reg[CORDIC_ITERS] : x_reg[CORDIC_ITERS];
        y_f = neg_reg[CORDIC_ITERS] ? -y_reg[CORDIC_ITERS] : y_reg[CORDIC_ITERS];
        x_r = (x_f + RND_HALF) >>> RND_SH;
        y_r = (y_f + RND_HALF) >>> RND_SH;
        if (x_r > ONE_Q)
        begin
            x_r = ONE_Q;
        end
        if (x_r < -ONE_Q)
        begin
            x_r = -ONE_Q;
        end
        if (y_r > ONE_Q)
        begin
            y_r = ONE_Q;
        end
        if (y_r < -ONE_Q)
        begin
            y_r = -ONE_Q;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= x_r[TRIG_W-1:0];
            sin_reg <= y_r[TRIG_W-1:0];
        end
    end

    assign sin_q = sin_reg;
    assign cos_q = cos_reg;

endmodule

[sv/lpg_matmul.sv]
// two-stage 3x3 fixed-point matrix product with half-up rounding
module lpg_matmul
    import lpg_pkg::*;
(
    input  logic clk,
    input  logic en,
    input  mat_t a,
    input  mat_t b,
    output mat_t r
);

    localparam logic signed [MSUM_W-1:0] RND_HALF = MSUM_W'(64'd1 << (TRIG_FRAC_BITS - 1));

    logic signed [PROD_W-1:0] prod_reg [3][3][3];
    logic signed [MSUM_W-1:0] sum_c [3][3];
    mat_t                     r_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        prod_reg[i][j][k] <= $signed(a[i][k]) * $signed(b[k][j]);
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum_c[i][j] = (MSUM_W'(prod_reg[i][j][0]) + MSUM_W'(prod_reg[i][j][1])
                    + MSUM_W'(prod_reg[i][j][2]) + RND_HALF) >>> TRIG_FRAC_BITS;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    r_reg[i][j] <= sum_c[i][j][ENT_W-1:0];
                end
            end
        end
    end

    assign r = r_reg;

endmodule

[sv/lpg_rot.sv]
// omega-phi-kappa rotation matrix Mk*(Mf*Mw) from sines and cosines
module lpg_rot
    import lpg_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  trig_t s_om,
    input  trig_t c_om,
    input  trig_t s_ph,
    input  trig_t c_ph,
    input  trig_t s_ka,
    input  trig_t c_ka,
    output mat_t  rot
);

    localparam ent_t ONE = ENT_W'(64'd1 << TRIG_FRAC_BITS);

    mat_t mw;
    mat_t mf;
    mat_t mk;
    mat_t t_m;
    mat_t mk_dly_reg [0:MM_LAT-1];

    always_comb
    begin
        mw[0][0] = ONE;              mw[0][1] = '0;                mw[0][2] = '0;
        mw[1][0] = '0;               mw[1][1] = ENT_W'(c_om);      mw[1][2] = ENT_W'(s_om);
        mw[2][0] = '0;               mw[2][1] = -ENT_W'(s_om);     mw[2][2] = ENT_W'(c_om);
        mf[0][0] = ENT_W'(c_ph);     mf[0][1] = '0;                mf[0][2] = -ENT_W'(s_ph);
        mf[1][0] = '0;               mf[1][1] = ONE;               mf[1][2] = '0;
        mf[2][0] = ENT_W'(s_ph);     mf[2][1] = '0;                mf[2][2] = ENT_W'(c_ph);
        mk[0][0] = ENT_W'(c_ka);     mk[0][1] = ENT_W'(s_ka);      mk[0][2] = '0;
        mk[1][0] = -ENT_W'(s_ka);    mk[1][1] = ENT_W'(c_ka);      mk[1][2] = '0;
        mk[2][0] = '0;               mk[2][1] = '0;                mk[2][2] = ONE;
    end

    lpg_matmul u_mul_fw
    (
        .clk (clk),
        .en  (en),
        .a   (mf),
        .b   (mw),
        .r   (t_m)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mk_dly_reg[0] <= mk;
            for (int i = 1; i < MM_LAT; i++)
            begin
                mk_dly_reg[i] <= mk_dly_reg[i-1];
            end
        end
    end

    lpg_matmul u_mul_k
    (
        .clk (clk),
        .en  (en),
        .a   (mk_dly_reg[MM_LAT-1]),
        .b   (t_m),
        .r   (rot)
    );

endmodule

[sv/lidar_point_georeference_top.sv]
// lidar direct georeferencing pipeline: polar return to ground coordinates
//
// usage:
//   input channel in_valid/in_ready carries one lidar return per transaction:
//   time tag, platform position, platform attitude, scanner angles and range.
//   output channel out_valid/out_ready carries the ground point, the copied
//   time tag and a saturation flag, one result per input transaction.
//   configuration: cfg_we writes cfg_data[15:0] into register cfg_index
//   (lever arm x/y/z, boresight omega/phi/kappa); indexes 6 and 7 are dropped.
//   write only while no transaction is in flight.
// pipeline: from input transaction to out_valid, through the 32-stage
//   cordic lanes, the three chained matrix products and the final
//   sum and clip.
// throughput: one transaction per cycle while the output is not stalled.
// reset: rst_n clears all valid bits and the configuration registers to 0.
// stall: while the output register holds an untaken result and the last
//   pipeline stage is also full, the whole pipeline freezes and in_ready
//   drops; bubbles otherwise keep moving and new input is still taken.
module lidar_point_georeference_top
    import lpg_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]            cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [TIME_W-1:0]           time_tag,
    input  logic signed [POS_BITS-1:0]  platform_x,
    input  logic signed [POS_BITS-1:0]  platform_y,
    input  logic signed [POS_BITS-1:0]  platform_z,
    input  logic signed [ANGLE_W-1:0]   platform_omega,
    input  logic signed [ANGLE_W-1:0]   platform_phi,
    input  logic signed [ANGLE_W-1:0]   platform_kappa,
    input  logic signed [ANGLE_W-1:0]   vertical_angle,
    input  logic signed [ANGLE_W-1:0]   horizontal_angle,
    input  logic [RANGE_W-1:0]          slant_range,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [TIME_W-1:0]           out_time_tag,
    output logic signed [POS_BITS-1:0]  ground_x,
    output logic signed [POS_BITS-1:0]  ground_y,
    output logic signed [POS_BITS-1:0]  ground_z,
    output logic                        saturated
);

    localparam int SP_W = RANGE_W + TRIG_W + 1;
    localparam int ST_W = SV_W + TRIG_W;
    localparam logic signed [SP_W-1:0]  SP_HALF  = SP_W'(64'd1 << (TRIG_FRAC_BITS - 1));
    localparam logic signed [ST_W-1:0]  ST_HALF  = ST_W'(64'd1 << (TRIG_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(64'd1 << (TRIG_FRAC_BITS - 1));
    localparam logic signed [GND_W-1:0] GND_MAX  = GND_W'((64'd1 << (POS_BITS - 1)) - 1);
    localparam logic signed [GND_W-1:0] GND_MIN  = -GND_MAX - GND_W'(1);

    logic signed [CFG_W-1:0] lever_x_reg;
    logic signed [CFG_W-1:0] lever_y_reg;
    logic signed [CFG_W-1:0] lever_z_reg;
    logic signed [CFG_W-1:0] bs_om_reg;
    logic signed [CFG_W-1:0] bs_ph_reg;
    logic signed [CFG_W-1:0] bs_ka_reg;
    logic signed [CFG_W-1:0] lev [3];

    logic                        adv;
    logic                        pv_reg [0:PIPE_LAT-1];
    logic [TIME_W-1:0]           time_dly_reg [0:PIPE_LAT-1];
    logic signed [POS_BITS-1:0]  pos_dly_reg [0:PIPE_LAT-1][3];
    logic [RANGE_W-1:0]          rng_dly_reg [0:CORDIC_LAT-1];

    trig_t s_pom, c_pom, s_pph, c_pph, s_pka, c_pka;
    trig_t s_bom, c_bom, s_bph, c_bph, s_bka, c_bka;
    trig_t s_v, c_v, s_h, c_h;

    mat_t rp;
    mat_t rb;
    mat_t m_tot;
    mat_t rp_dly_reg [0:RP_DLY-1];

    logic signed [SP_W-1:0]  t_prod;
    logic signed [SP_W-1:0]  z_prod;
    logic signed [SV_W-1:0]  t_reg;
    logic signed [SV_W-1:0]  sz1_reg;
    trig_t                   sh_reg;
    trig_t                   ch_reg;
    logic signed [ST_W-1:0]  x_prod;
    logic signed [ST_W-1:0]  y_prod;
    logic signed [SV_W-1:0]  sv_reg [3];
    logic signed [SV_W-1:0]  s_dly_reg [0:SCAN_DLY-1][3];

    logic signed [ACC_W-1:0] plev_reg [3][3];
    logic signed [ACC_W-1:0] pscan_reg [3][3];
    logic signed [ACC_W-1:0] acc_c [3];
    logic signed [OFF_W-1:0] off_reg [3];

    logic signed [GND_W-1:0]    g_c [3];
    logic signed [POS_BITS-1:0] g_clip [3];
    logic                       sat_c;

    logic                       out_valid_reg;
    logic [TIME_W-1:0]          out_time_reg;
    logic signed [POS_BITS-1:0] ground_reg [3];
    logic                       sat_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lever_x_reg <= '0;
            lever_y_reg <= '0;
            lever_z_reg <= '0;
            bs_om_reg   <= '0;
            bs_ph_reg   <= '0;
            bs_ka_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LEVER_X:  lever_x_reg <= cfg_data;
                REG_LEVER_Y:  lever_y_reg <= cfg_data;
                REG_LEVER_Z:  lever_z_reg <= cfg_data;
                REG_BS_OMEGA: bs_om_reg   <= cfg_data;
                REG_BS_PHI:   bs_ph_reg   <= cfg_data;
                REG_BS_KAPPA: bs_ka_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign lev[0] = lever_x_reg;
    assign lev[1] = lever_y_reg;
    assign lev[2] = lever_z_reg;

    // global pipeline advance
    assign adv      = !(pv_reg[PIPE_LAT-1] && out_valid_reg && !out_ready);
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_LAT; i++)
            begin
                pv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            pv_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                pv_reg[i] <= pv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            time_dly_reg[0]   <= time_tag;
            pos_dly_reg[0][0] <= platform_x;
            pos_dly_reg[0][1] <= platform_y;
            pos_dly_reg[0][2] <= platform_z;
            rng_dly_reg[0]    <= slant_range;
            for (int i = 1; i < PIPE_LAT; i++)
            begin
                time_dly_reg[i] <= time_dly_reg[i-1];
                pos_dly_reg[i]  <= pos_dly_reg[i-1];
            end
            for (int i = 1; i < CORDIC_LAT; i++)
            begin
                rng_dly_reg[i] <= rng_dly_reg[i-1];
            end
        end
    end

    // sine and cosine lanes
    lpg_cordic u_cor_pom (.clk(clk), .en(adv), .angle(platform_omega),   .sin_q(s_pom), .cos_q(c_pom));
    lpg_cordic u_cor_pph (.clk(clk), .en(adv), .angle(platform_phi),     .sin_q(s_pph), .cos_q(c_pph));
    lpg_cordic u_cor_pka (.clk(clk), .en(adv), .angle(platform_kappa),   .sin_q(s_pka), .cos_q(c_pka));
    lpg_cordic u_cor_bom (.clk(clk), .en(adv), .angle(bs_om_reg),        .sin_q(s_bom), .cos_q(c_bom));
    lpg_cordic u_cor_bph (.clk(clk), .en(adv), .angle(bs_ph_reg),        .sin_q(s_bph), .cos_q(c_bph));
    lpg_cordic u_cor_bka (.clk(clk), .en(adv), .angle(bs_ka_reg),        .sin_q(s_bka), .cos_q(c_bka));
    lpg_cordic u_cor_ver (.clk(clk), .en(adv), .angle(vertical_angle),   .sin_q(s_v),   .cos_q(c_v));
    lpg_cordic u_cor_hor (.clk(clk), .en(adv), .angle(horizontal_angle), .sin_q(s_h),   .cos_q(c_h));

    // rotation matrices
    lpg_rot u_rot_plat
    (
        .clk  (clk),
        .en   (adv),
        .s_om (s_pom),
        .c_om (c_pom),
        .s_ph (s_pph),
        .c_ph (c_pph),
        .s_ka (s_pka),
        .c_ka (c_pka),
        .rot  (rp)
    );

    lpg_rot u_rot_bs
    (
        .clk  (clk),
        .en   (adv),
        .s_om (s_bom),
        .c_om (c_bom),
        .s_ph (s_bph),
        .c_ph (c_bph),
        .s_ka (s_bka),
        .c_ka (c_bka),
        .rot  (rb)
    );

    lpg_matmul u_mul_tot
    (
        .clk (clk),
        .en  (adv),
        .a   (rp),
        .b   (rb),
        .r   (m_tot)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rp_dly_reg[0] <= rp;
            for (int i = 1; i < RP_DLY; i++)
            begin
                rp_dly_reg[i] <= rp_dly_reg[i-1];
            end
        end
    end

    // scanner vector
    always_comb
    begin
        t_prod = $signed({1'b0, rng_dly_reg[CORDIC_LAT-1]}) * c_v;
        z_prod = $signed({1'b0, rng_dly_reg[CORDIC_LAT-1]}) * s_v;
        x_prod = t_reg * sh_reg;
        y_prod = t_reg * ch_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg     <= SV_W'((t_prod + SP_HALF) >>> TRIG_FRAC_BITS);
            sz1_reg   <= SV_W'((z_prod + SP_HALF) >>> TRIG_FRAC_BITS);
            sh_reg    <= s_h;
            ch_reg    <= c_h;
            sv_reg[0] <= SV_W'((x_prod + ST_HALF) >>> TRIG_FRAC_BITS);
            sv_reg[1] <= SV_W'((y_prod + ST_HALF) >>> TRIG_FRAC_BITS);
            sv_reg[2] <= sz1_reg;
            s_dly_reg[0] <= sv_reg;
            for (int i = 1; i < SCAN_DLY; i++)
            begin
                s_dly_reg[i] <= s_dly_reg[i-1];
            end
        end
    end

    // offset products and sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    plev_reg[i][k]  <= ACC_W'($signed(rp_dly_reg[RP_DLY-1][i][k]) * lev[k]);
                    pscan_reg[i][k] <= ACC_W'($signed(m_tot[i][k]) * s_dly_reg[SCAN_DLY-1][k]);
                end
            end
            for (int i = 0; i < 3; i++)
            begin
                off_reg[i] <= OFF_W'(acc_c[i] >>> TRIG_FRAC_BITS);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            acc_c[i] = plev_reg[i][0] + plev_reg[i][1] + plev_reg[i][2]
                + pscan_reg[i][0] + pscan_reg[i][1] + pscan_reg[i][2] + ACC_HALF;
        end
    end

    // position add and clip
    always_comb
    begin
        sat_c = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            g_c[i] = GND_W'(pos_dly_reg[PIPE_LAT-1][i]) + GND_W'(off_reg[i]);
            if (g_c[i] > GND_MAX)
            begin
                g_clip[i] = GND_MAX[POS_BITS-1:0];
                sat_c     = 1'b1;
            end
            else if (g_c[i] < GND_MIN)
            begin
                g_clip[i] = GND_MIN[POS_BITS-1:0];
                sat_c     = 1'b1;
            end
            else
            begin
                g_clip[i] = g_c[i][POS_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && pv_reg[PIPE_LAT-1])
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && pv_reg[PIPE_LAT-1])
        begin
            out_time_reg <= time_dly_reg[PIPE_LAT-1];
            ground_reg   <= g_clip;
            sat_reg      <= sat_c;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_time_tag = out_time_reg;
    assign ground_x     = ground_reg[0];
    assign ground_y     = ground_reg[1];
    assign ground_z     = ground_reg[2];
    assign saturated    = sat_reg;

    // input side never blocks while the output register is empty
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    // a blocked finished transaction stays in the last stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (pv_reg[PIPE_LAT-1] && out_valid && !out_ready) |=> (pv_reg[PIPE_LAT-1] && out_valid))
        else $error("finished transaction lost during stall");

    // a saturation flag comes with a clipped coordinate
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |->
            (ground_x == GND_MAX[POS_BITS-1:0] || ground_x == GND_MIN[POS_BITS-1:0] ||
             ground_y == GND_MAX[POS_BITS-1:0] || ground_y == GND_MIN[POS_BITS-1:0] ||
             ground_z == GND_MAX[POS_BITS-1:0] || ground_z == GND_MIN[POS_BITS-1:0]))
        else $error("saturation flag without clipped coordinate");

endmodule

[test/lidar_point_georeference_top_tb.sv]
// testbench for the lidar georeferencing pipeline: bit-true predictor, bursty driver, stalling sink
module lidar_point_georeference_top_tb
    import lpg_pkg::*;
;

    typedef struct {
        logic [TIME_W-1:0]          tt;
        logic signed [POS_BITS-1:0] px, py, pz;
        logic signed [ANGLE_W-1:0]  om, ph, ka, va, ha;
        logic [RANGE_W-1:0]         rng;
    } lidar_return_t;

    typedef struct {
        logic [TIME_W-1:0]   tt;
        logic [POS_BITS-1:0] gx, gy, gz;
        logic                sat;
    } ground_point_t;

    typedef longint mat3_t [3][3];

    localparam longint ATAN_Q30 [30] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
        64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
        64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
        64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
    };

    logic clk, rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [TIME_W-1:0] time_tag, out_time_tag;
    logic signed [POS_BITS-1:0] platform_x, platform_y, platform_z;
    logic signed [ANGLE_W-1:0] platform_omega, platform_phi, platform_kappa;
    logic signed [ANGLE_W-1:0] vertical_angle, horizontal_angle;
    logic [RANGE_W-1:0] slant_range;
    logic signed [POS_BITS-1:0] ground_x, ground_y, ground_z;
    logic saturated;

    lidar_return_t pending_returns[$];
    ground_point_t expected_points[$];
    logic signed [CFG_W-1:0] shadow_regs [6];
    int errors = 0;
    int points_checked = 0;
    int sat_points = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;

    lidar_point_georeference_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_unit(longint v);
        longint r;
        r = round_shift(v, 30 - TRIG_FRAC_BITS);
        if (r > (longint'(1) <<< TRIG_FRAC_BITS)) r = longint'(1) <<< TRIG_FRAC_BITS;
        if (r < -(longint'(1) <<< TRIG_FRAC_BITS)) r = -(longint'(1) <<< TRIG_FRAC_BITS);
        return r;
    endfunction

    task automatic sin_cos(input longint ang, output longint sn, output longint cs);
        longint z, x, y, xn;
        bit flip;
        z = ang * 65536;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > (longint'(1) <<< 30))
        begin
            z -= longint'(1) <<< 31;
            flip = 1'b1;
        end
        else if (z < -(longint'(1) <<< 30))
        begin
            z += longint'(1) <<< 31;
            flip = 1'b1;
        end
        for (int i = 0; i < 30; i++)
        begin
            if (z >= 0)
            begin
                xn = x - (y >>> i); y = y + (x >>> i); z -= ATAN_Q30[i];
            end
            else
            begin
                xn = x + (y >>> i); y = y - (x >>> i); z += ATAN_Q30[i];
            end
            x = xn;
        end
        if (flip)
        begin
            x = -x; y = -y;
        end
        sn = clamp_unit(y);
        cs = clamp_unit(x);
    endtask

    task automatic mat_product(input mat3_t a, input mat3_t b, output mat3_t r);
        longint acc;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                acc = 0;
                for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
                r[i][j] = round_shift(acc, TRIG_FRAC_BITS);
            end
    endtask

    task automatic attitude_matrix(input longint om, input longint ph, input longint ka,
                                   output mat3_t r);
        longint sw, cw, sf, cf, sk, ck, one;
        mat3_t mw, mf, mk, t;
        one = longint'(1) <<< TRIG_FRAC_BITS;
        sin_cos(om, sw, cw);
        sin_cos(ph, sf, cf);
        sin_cos(ka, sk, ck);
        mw = '{'{one, 0, 0}, '{0, cw, sw}, '{0, -sw, cw}};
        mf = '{'{cf, 0, -sf}, '{0, one, 0}, '{sf, 0, cf}};
        mk = '{'{ck, sk, 0}, '{-sk, ck, 0}, '{0, 0, one}};
        mat_product(mf, mw, t);
        mat_product(mk, t, r);
    endtask

    task automatic georeference(input lidar_return_t p, output ground_point_t g);
        mat3_t rp, rb, m;
        longint lev[3], pos[3], sv[3];
        longint snv, csv, snh, csh, t, acc, gc, maxv, minv;
        maxv = (longint'(1) <<< (POS_BITS - 1)) - 1;
        minv = -maxv - 1;
        for (int i = 0; i < 3; i++) lev[i] = longint'(shadow_regs[i]);
        pos[0] = longint'(p.px);
        pos[1] = longint'(p.py);
        pos[2] = longint'(p.pz);
        attitude_matrix(longint'(p.om), longint'(p.ph), longint'(p.ka), rp);
        attitude_matrix(longint'(shadow_regs[3]), longint'(shadow_regs[4]),
                        longint'(shadow_regs[5]), rb);
        mat_product(rp, rb, m);
        sin_cos(longint'(p.va), snv, csv);
        sin_cos(longint'(p.ha), snh, csh);
        t = round_shift(longint'(p.rng) * csv, TRIG_FRAC_BITS);
        sv[0] = round_shift(t * snh, TRIG_FRAC_BITS);
        sv[1] = round_shift(t * csh, TRIG_FRAC_BITS);
        sv[2] = round_shift(longint'(p.rng) * snv, TRIG_FRAC_BITS);
        g.tt = p.tt;
        g.sat = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += rp[i][k] * lev[k] + m[i][k] * sv[k];
            gc = pos[i] + round_shift(acc, TRIG_FRAC_BITS);
            if (gc > maxv)
            begin
                gc = maxv; g.sat = 1'b1;
            end
            if (gc < minv)
            begin
                gc = minv; g.sat = 1'b1;
            end
            if (i == 0) g.gx = gc[POS_BITS-1:0];
            else if (i == 1) g.gy = gc[POS_BITS-1:0];
            else g.gz = gc[POS_BITS-1:0];
        end
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    task automatic queue_return(input lidar_return_t p);
        pending_returns = {pending_returns, p};
    endtask

    function automatic logic [POS_BITS-1:0] rand_pos();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return r[POS_BITS-1:0];
            1: return POS_BITS'(signed'(r[20:0]));
            2: return {2'b01, r[POS_BITS-3:0]} | {{(POS_BITS-18){1'b1}}, 18'h0};
            default: return {2'b10, r[POS_BITS-3:0]} & {{(POS_BITS-18){1'b0}}, 18'h3ffff}
                            | {2'b10, {(POS_BITS-2){1'b0}}};
        endcase
    endfunction

    function automatic lidar_return_t rand_return();
        lidar_return_t p;
        p.tt = TIME_W'({$urandom, $urandom});
        p.px = rand_pos();
        p.py = rand_pos();
        p.pz = rand_pos();
        p.om = ANGLE_W'($urandom); p.ph = ANGLE_W'($urandom); p.ka = ANGLE_W'($urandom);
        p.va = ANGLE_W'($urandom); p.ha = ANGLE_W'($urandom);
        p.rng = ($urandom_range(0, 3) == 0) ? RANGE_W'($urandom_range(0, 300)) : RANGE_W'($urandom);
        return p;
    endfunction

    function automatic lidar_return_t make_return(logic [TIME_W-1:0] tt, longint pv,
                                                  logic signed [ANGLE_W-1:0] a,
                                                  logic signed [ANGLE_W-1:0] va,
                                                  logic signed [ANGLE_W-1:0] ha,
                                                  logic [RANGE_W-1:0] rng);
        lidar_return_t p;
        p.tt = tt;
        p.px = pv[POS_BITS-1:0]; p.py = pv[POS_BITS-1:0]; p.pz = pv[POS_BITS-1:0];
        p.om = a; p.ph = a; p.ka = a;
        p.va = va; p.ha = ha; p.rng = rng;
        return p;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do @(posedge clk);
        while (pending_returns.size() != 0 || in_valid || expected_points.size() != 0);
        repeat (60) @(posedge clk);
    endtask

    // mirror of the configuration registers, updated on the same edge as the block
    always @(posedge clk)
        if (cfg_we && cfg_index <= REG_BS_KAPPA) shadow_regs[cfg_index] <= cfg_data;

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            lidar_return_t cur, nxt;
            ground_point_t g;
            if (in_valid && in_ready)
            begin
                cur.tt = time_tag; cur.px = platform_x; cur.py = platform_y; cur.pz = platform_z;
                cur.om = platform_omega; cur.ph = platform_phi; cur.ka = platform_kappa;
                cur.va = vertical_angle; cur.ha = horizontal_angle; cur.rng = slant_range;
                georeference(cur, g);
                expected_points = {expected_points, g};
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_returns.size() != 0)
                begin
                    nxt = pending_returns.pop_front();
                    time_tag <= nxt.tt;
                    platform_x <= nxt.px; platform_y <= nxt.py; platform_z <= nxt.pz;
                    platform_omega <= nxt.om; platform_phi <= nxt.ph; platform_kappa <= nxt.ka;
                    vertical_angle <= nxt.va; horizontal_angle <= nxt.ha;
                    slant_range <= nxt.rng;
                    in_valid <= 1'b1;
                    if (burst_left > 0) burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(0, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and sink stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            ground_point_t w;
            if (out_valid && out_ready)
            begin
                if (expected_points.size() == 0)
                begin
                    report("unexpected transaction", ground_x, 64'd0);
                end
                else
                begin
                    w = expected_points.pop_front();
                    points_checked++;
                    if (w.sat) sat_points++;
                    if (out_time_tag !== w.tt) report("out_time_tag", out_time_tag, w.tt);
                    if (ground_x !== w.gx) report("ground_x", ground_x, w.gx);
                    if (ground_y !== w.gy) report("ground_y", ground_y, w.gy);
                    if (ground_z !== w.gz) report("ground_z", ground_z, w.gz);
                    if (saturated !== w.sat) report("saturated", saturated, w.sat);
                end
            end
            if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 3) != 0);
                2: out_ready <= ($urandom_range(0, 1) != 0);
                default: out_ready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    initial
    begin
        logic [CFG_W-1:0] extremes [4];
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        time_tag = '0; platform_x = '0; platform_y = '0; platform_z = '0;
        platform_omega = '0; platform_phi = '0; platform_kappa = '0;
        vertical_angle = '0; horizontal_angle = '0; slant_range = '0;
        for (int i = 0; i < 6; i++) shadow_regs[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration, directed returns
        queue_return(make_return(48'd0, 64'sd0, 16'sd0, 16'sd0, 16'sd0, 18'd0));
        queue_return(make_return('1, 64'sd17179869183, 16'sh7fff, 16'sh7fff,
                                 16'sh7fff, '1));
        queue_return(make_return('1, -64'sd17179869184, -16'sh8000, -16'sh8000,
                                 -16'sh8000, '1));
        queue_return(make_return(48'd1, 64'sd17179869183, 16'sd0, 16'sh4000, 16'sd0, '1));
        queue_return(make_return(48'd2, -64'sd17179869184, 16'sd0, -16'sh4000, 16'sd0, '1));
        queue_return(make_return(48'd3, 64'sd17179869183, 16'sd0, 16'sd0, 16'sd0, '1));
        queue_return(make_return(48'd4, -64'sd17179869184, 16'sh4000, 16'sd0, 16'sh4000,
                                 '1));
        queue_return(make_return(48'd5, 64'sd1000, 16'sh4000, 16'sh4000, -16'sh4000,
                                 18'd100000));
        queue_return(make_return(48'd6, -64'sd1000, -16'sh4000, 16'sh2000, 16'sh6000,
                                 18'd5));
        queue_return(make_return(48'd7, 64'sd0, 16'sh4001, 16'sh3fff, -16'sh4001, 18'd1));
        queue_return(make_return(48'h5555_5555_5555, 64'sh2_aaaa_aaaa, 16'sh5555,
                                 -16'sh2aab, 16'sh1234, 18'h2aaaa));
        queue_return(make_return(48'haaaa_aaaa_aaaa, 64'sh5_5555_5555, -16'sh5556,
                                 16'sh2aaa, -16'sh1234, 18'h15555));
        for (int i = 0; i < 130; i++) queue_return(rand_return());
        drain();

        extremes = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        for (int ph = 0; ph < 6; ph++)
        begin
            for (int r = 0; r < 6; r++)
                write_reg(CFG_IDX_W'(r), (ph < 4) ? extremes[ph] : CFG_W'($urandom));
            // writes past the last register must leave everything untouched
            write_reg(3'd6, CFG_W'($urandom));
            write_reg(3'd7, CFG_W'($urandom));
            if (ph == 0)
                queue_return(make_return(48'd9, 64'sd17179869183, 16'sd0, 16'sd0, 16'sd0, '1));
            if (ph == 1)
                queue_return(make_return(48'd9, -64'sd17179869184, 16'sd0, 16'sd0, 16'sd0, '1));
            for (int i = 0; i < 110; i++) queue_return(rand_return());
            drain();
        end

        $display("checked %0d ground points over 7 register settings, %0d of them clipped",
                 points_checked, sat_points);
        if (errors == 0)
            $display("lidar_point_georeference_top verification clean");
        else
            $display("lidar_point_georeference_top verification failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("timeout with %0d points outstanding", expected_points.size());
        $display("lidar_point_georeference_top verification failed");
        $finish;
    end

endmodule
